>>> hdl/fwg_pkg.sv
// Package for the four-waveform tone generator.
// Holds widths, codes, the configuration struct and the quarter-wave sine ROM builder.
// No dependencies.
package fwg_pkg;

  localparam int PhaseBits = 32;
  localparam int SineDepth = 1024;
  localparam int RomAddrW  = $clog2(SineDepth + 1);
  localparam int KProdW    = PhaseBits - 2 + RomAddrW;
  localparam int RomW      = 16;
  localparam int UnitW     = 17;
  localparam int AmpW      = 15;
  localparam int ModeW     = 2;
  localparam int SampleW   = 16;
  localparam int ProdW     = 32;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int FracShift = 15;

  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint Q30One    = 64'sd1073741824;
  localparam longint Q30Half   = Q30One / 2;

  // Taylor divisors (2n)(2n+1) for n = 1..8
  localparam longint TaylorDiv [1:8] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                         64'sd110, 64'sd156, 64'sd210, 64'sd272};

  typedef enum logic [ModeW-1:0] {
    WaveSine     = 2'd0,
    WaveSaw      = 2'd1,
    WaveSquare   = 2'd2,
    WaveTriangle = 2'd3
  } wave_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode      = 2'd0,
    RegAmplitude = 2'd1,
    RegPhaseStep = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    wave_e                mode;
    logic [AmpW-1:0]      amplitude;
    logic [PhaseBits-1:0] step;
  } cfg_t;

  typedef logic [RomW-1:0] sine_rom_t [SineDepth+1];

  // Q2.30 Taylor series, round half up, clamped to 0..32768
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    longint    x;
    longint    term;
    longint    sum;
    longint    v;
    int        k;
    int        n;
    for (k = 0; k <= SineDepth; k++) begin
      x    = (longint'(k) * HalfPiQ30) / SineDepth;
      term = x;
      sum  = x;
      for (n = 1; n <= 8; n++) begin
        term = term * x / Q30One;
        term = term * x / Q30One;
        term = -term / TaylorDiv[n];
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      v = (sum * 32768 + Q30Half) / Q30One;
      if (v > 32768) v = 32768;
      rom[k] = v[RomW-1:0];
    end
    return rom;
  endfunction

endpackage

>>> hdl/fwg_phase_acc.sv
// Phase accumulator stage of the tone generator.
// Depends on fwg_pkg.
module fwg_phase_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fwg_pkg::PhaseBits-1:0] step_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          restart_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [fwg_pkg::PhaseBits-1:0] phase_o
);

  logic                          acc_valid_q;
  logic [fwg_pkg::PhaseBits-1:0] phase_q, phase_d;
  logic [fwg_pkg::PhaseBits-1:0] ph_now;
  logic [fwg_pkg::PhaseBits-1:0] ph_out_q;
  logic                          take;

  assign ready_o = !acc_valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign ph_now  = restart_i ? '0 : phase_q;
  assign phase_d = ph_now + step_i;   // wraps modulo 2^PhaseBits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      acc_valid_q <= 1'b0;
    end else begin
      if (take) phase_q <= phase_d;
      if (ready_o) acc_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) ph_out_q <= ph_now;
  end

  assign valid_o = acc_valid_q;
  assign phase_o = ph_out_q;

endmodule

>>> hdl/fwg_wave.sv
// Waveform stage: quarter-wave sine ROM read plus sawtooth, square and triangle.
// Depends on fwg_pkg.
module fwg_wave (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fwg_pkg::wave_e                mode_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [fwg_pkg::PhaseBits-1:0] phase_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [fwg_pkg::RomW-1:0]      rom_o,
  output logic                          neg_o,
  output logic signed [fwg_pkg::UnitW-1:0] alt_o
);

  localparam fwg_pkg::sine_rom_t SineRom = fwg_pkg::sine_rom_build();
  localparam int TriW = fwg_pkg::PhaseBits + 16;

  logic                              wv_valid_q;
  logic                              take;
  logic [1:0]                        quad;
  logic [fwg_pkg::PhaseBits-3:0]     frac;
  logic [fwg_pkg::KProdW-1:0]        k_full;
  logic [fwg_pkg::RomAddrW-1:0]      k;
  logic [fwg_pkg::RomAddrW-1:0]      idx;
  logic                              msb;
  logic [fwg_pkg::PhaseBits-1:0]     tri_dist;
  logic [TriW-1:0]                   tri_full;
  logic signed [fwg_pkg::UnitW:0]    tri_u;
  logic signed [fwg_pkg::UnitW-1:0]  alt_u;
  logic [fwg_pkg::RomW-1:0]          rom_q;
  logic                              neg_q;
  logic signed [fwg_pkg::UnitW-1:0]  alt_q;

  assign ready_o = !wv_valid_q || ready_i;
  assign take    = valid_i && ready_o;

  assign quad   = phase_i[fwg_pkg::PhaseBits-1 -: 2];
  assign frac   = phase_i[fwg_pkg::PhaseBits-3:0];
  assign k_full = (fwg_pkg::KProdW'(frac) * fwg_pkg::KProdW'(fwg_pkg::SineDepth))
                  >> (fwg_pkg::PhaseBits - 2);
  assign k      = k_full[fwg_pkg::RomAddrW-1:0];
  // odd quadrants run the table backwards
  assign idx    = quad[0] ? (fwg_pkg::RomAddrW'(fwg_pkg::SineDepth) - k) : k;

  // triangle: distance to the nearest whole cycle, scaled to 0..65536
  assign msb      = phase_i[fwg_pkg::PhaseBits-1];
  assign tri_dist = msb ? (~phase_i + 1'b1) : phase_i;
  assign tri_full = {tri_dist, 16'b0} >> (fwg_pkg::PhaseBits - 1);
  assign tri_u    = $signed({1'b0, tri_full[fwg_pkg::UnitW-1:0]})
                    - $signed((fwg_pkg::UnitW+1)'(32768));

  always_comb begin
    unique case (mode_i)
      fwg_pkg::WaveSaw:
        alt_u = $signed({2'b00, phase_i[fwg_pkg::PhaseBits-1 -: 15]});
      fwg_pkg::WaveSquare:
        alt_u = msb ? -$signed(fwg_pkg::UnitW'(32768)) : $signed(fwg_pkg::UnitW'(32768));
      fwg_pkg::WaveTriangle:
        alt_u = tri_u[fwg_pkg::UnitW-1:0];
      default:
        alt_u = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_valid_q <= 1'b0;
    end else if (ready_o) begin
      wv_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rom_q <= SineRom[idx];
      neg_q <= quad[1];
      alt_q <= alt_u;
    end
  end

  assign valid_o = wv_valid_q;
  assign rom_o   = rom_q;
  assign neg_o   = neg_q;
  assign alt_o   = alt_q;

endmodule

>>> hdl/fwg_scale.sv
// Amplitude scaling: multiply, truncate toward zero, saturate to 16 bits.
// Depends on fwg_pkg.
module fwg_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fwg_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [fwg_pkg::RomW-1:0]         rom_i,
  input  logic                             neg_i,
  input  logic signed [fwg_pkg::UnitW-1:0] alt_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic signed [fwg_pkg::SampleW-1:0] sample_o
);

  logic                               mul_valid_q;
  logic                               out_valid_q;
  logic                               out_ready;
  logic                               take;
  logic signed [fwg_pkg::UnitW-1:0]   sine_u;
  logic signed [fwg_pkg::UnitW-1:0]   unit_u;
  logic signed [fwg_pkg::ProdW-1:0]   prod_d, prod_q;
  logic signed [fwg_pkg::ProdW-1:0]   biased;
  logic signed [fwg_pkg::ProdW-1:0]   shifted;
  logic signed [fwg_pkg::SampleW-1:0] sat;
  logic signed [fwg_pkg::SampleW-1:0] sample_q;

  assign out_ready = !out_valid_q || !stall_i;
  assign ready_o   = !mul_valid_q || out_ready;
  assign take      = valid_i && ready_o;

  assign sine_u = neg_i ? -$signed({1'b0, rom_i}) : $signed({1'b0, rom_i});
  assign unit_u = (cfg_i.mode == fwg_pkg::WaveSine) ? sine_u : alt_i;
  assign prod_d = $signed({1'b0, cfg_i.amplitude}) * unit_u;

  // toward zero: bias negatives by 2^15-1 before the arithmetic shift
  assign biased  = prod_q + (prod_q[fwg_pkg::ProdW-1] ?
                             fwg_pkg::ProdW'(32767) : fwg_pkg::ProdW'(0));
  assign shifted = biased >>> fwg_pkg::FracShift;

  always_comb begin
    if (shifted > $signed(fwg_pkg::ProdW'(32767))) begin
      sat = 16'sh7fff;
    end else if (shifted < -$signed(fwg_pkg::ProdW'(32768))) begin
      sat = 16'sh8000;
    end else begin
      sat = shifted[fwg_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) mul_valid_q <= valid_i;
      if (out_ready) out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) prod_q <= prod_d;
    if (out_ready && mul_valid_q) sample_q <= sat;
  end

  assign valid_o  = out_valid_q;
  assign sample_o = sample_q;

endmodule

>>> hdl/four_waveform_generator.sv
// Top level of the four-waveform DDS tone generator.
// Depends on fwg_pkg, fwg_phase_acc, fwg_wave and fwg_scale.
//
// One input word (restart flag) yields one 16-bit signed sample. The block
// takes one word per clock unless out_stall_i holds a full pipeline, and
// has four register stages: phase accumulator, sine ROM read (the
// 1025-entry quarter-wave table has a registered read port), amplitude
// multiply, and truncate/saturate into the output register.
// Every stage holds its own valid bit, so a word is still taken while a
// finished sample waits, as long as some stage further down has a bubble.
// Registers (write only while the block is idle): 0 waveform mode
// (sine, sawtooth, square, triangle), 1 amplitude, 2 phase step. Writes to
// index 3 are ignored. Restart clears the phase before the sample is formed;
// the phase then advances by the step, wrapping modulo 2^32.
module four_waveform_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fwg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fwg_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fwg_pkg::SampleW-1:0] sample_o
);

  fwg_pkg::cfg_t cfg_q;

  logic                             in_ready;
  logic                             ph_valid, ph_ready;
  logic [fwg_pkg::PhaseBits-1:0]    ph;
  logic                             wv_valid, wv_ready;
  logic [fwg_pkg::RomW-1:0]         wv_rom;
  logic                             wv_neg;
  logic signed [fwg_pkg::UnitW-1:0] wv_alt;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= fwg_pkg::WaveSine;
      cfg_q.amplitude <= '0;
      cfg_q.step      <= '0;
    end else if (cfg_valid_i) begin
      unique case (fwg_pkg::cfg_reg_e'(cfg_index_i))
        fwg_pkg::RegMode:
          cfg_q.mode <= fwg_pkg::wave_e'(cfg_data_i[fwg_pkg::ModeW-1:0]);
        fwg_pkg::RegAmplitude:
          cfg_q.amplitude <= cfg_data_i[fwg_pkg::AmpW-1:0];
        fwg_pkg::RegPhaseStep:
          cfg_q.step <= cfg_data_i[fwg_pkg::PhaseBits-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  fwg_phase_acc u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (cfg_q.step),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready),
    .restart_i (restart_i),
    .valid_o   (ph_valid),
    .ready_i   (ph_ready),
    .phase_o   (ph)
  );

  assign in_stall_o = !in_ready;

  fwg_wave u_wave (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (cfg_q.mode),
    .valid_i (ph_valid),
    .ready_o (ph_ready),
    .phase_i (ph),
    .valid_o (wv_valid),
    .ready_i (wv_ready),
    .rom_o   (wv_rom),
    .neg_o   (wv_neg),
    .alt_o   (wv_alt)
  );

  fwg_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (wv_valid),
    .ready_o  (wv_ready),
    .rom_i    (wv_rom),
    .neg_i    (wv_neg),
    .alt_i    (wv_alt),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .sample_o (sample_o)
  );

endmodule

>>> hdl/fwg_checker.sv
// Port-level checker for the tone generator, bound to the top level.
// Depends on fwg_pkg and four_waveform_generator.
module fwg_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [fwg_pkg::SampleW-1:0] sample_o
);

  // a held sample keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled sample changed or dropped");

  // input only stalls when a sample is held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a taken word reaches the output through all four stages when the output flows
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("word did not reach the output in four cycles");

  // amplitude tops out at 32767, so the negative rail is never reached
  a_no_neg_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o != 16'sh8000)
    else $error("sample hit -32768");

endmodule

bind four_waveform_generator fwg_checker u_fwg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_o    (sample_o)
);

>>> tb/four_waveform_generator_checker.sv
// Scoreboard for the four-waveform tone generator: tracks register writes,
// predicts one sample per accepted word and compares it with the output.
// Depends on fwg_pkg for widths and register and waveform codes.
module four_waveform_generator_checker
  import fwg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      restart_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [SampleW-1:0] sample_i,
  output int                        mismatches_o,
  output int                        samples_due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // pi/2 in Q2.30, and one in Q2.30
  localparam longint QuarterTurnQ30 = 64'sd1686629713;
  localparam longint OneQ30         = 64'sd1073741824;
  localparam int     UnitFull       = 32768;

  int                        quarter_sine [SineDepth+1];
  wave_e                     wave_sel;
  logic [AmpW-1:0]           amp_reg;
  logic [PhaseBits-1:0]      step_reg;
  logic [PhaseBits-1:0]      osc_phase;
  logic signed [SampleW-1:0] sample_q [$];
  logic signed [SampleW-1:0] due;
  int                        fault_count;

  // sine of (pi/2 * k / depth), the angle plus eight Taylor terms, rounded half up to 2^-15
  function automatic int sine_entry(int k);
    longint angle;
    longint term;
    longint series;
    longint rounded;
    angle  = (longint'(k) * QuarterTurnQ30) / SineDepth;
    term   = angle;
    series = angle;
    for (int n = 1; n <= 8; n++) begin
      term   = term * angle / OneQ30;
      term   = term * angle / OneQ30;
      term   = -term / longint'((2 * n) * (2 * n + 1));
      series = series + term;
    end
    if (series < 0) series = 0;
    rounded = (series * UnitFull + OneQ30 / 2) / OneQ30;
    return (rounded > UnitFull) ? UnitFull : int'(rounded);
  endfunction

  function automatic logic signed [SampleW-1:0] wave_sample(wave_e sel,
                                                            logic [AmpW-1:0] amp,
                                                            logic [PhaseBits-1:0] ph);
    longint level;
    longint fold;
    longint scaled;
    int     k;
    case (sel)
      WaveSine: begin
        k     = int'((longint'(ph[PhaseBits-3:0]) * SineDepth) >> (PhaseBits - 2));
        level = ph[PhaseBits-2] ? quarter_sine[SineDepth-k] : quarter_sine[k];
        if (ph[PhaseBits-1]) level = -level;
      end
      WaveSaw: level = longint'(ph >> (PhaseBits - 15));
      WaveSquare: level = ph[PhaseBits-1] ? -UnitFull : UnitFull;
      default: begin
        fold  = ph[PhaseBits-1] ? (longint'(1) << PhaseBits) - longint'(ph) : longint'(ph);
        level = ((fold << 16) >> (PhaseBits - 1)) - UnitFull;
      end
    endcase
    scaled = (longint'(amp) * level) / UnitFull;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    return scaled[SampleW-1:0];
  endfunction

  initial begin
    for (int k = 0; k <= SineDepth; k++) quarter_sine[k] = sine_entry(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel    = WaveSine;
      amp_reg     = '0;
      step_reg    = '0;
      osc_phase   = '0;
      fault_count = 0;
      sample_q.delete();
      mismatches_o  <= 0;
      samples_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegMode:      wave_sel = wave_e'(cfg_data_i[ModeW-1:0]);
          RegAmplitude: amp_reg  = cfg_data_i[AmpW-1:0];
          RegPhaseStep: step_reg = cfg_data_i[PhaseBits-1:0];
          default: ;  // spare index, no register behind it
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (restart_i) osc_phase = '0;
        sample_q.push_back(wave_sample(wave_sel, amp_reg, osc_phase));
        osc_phase = osc_phase + step_reg;
      end
      if (out_valid_i && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          fault_count++;
          $display("%0t: sample %0d with none expected", $time, sample_i);
        end else begin
          due = sample_q.pop_front();
          if (due !== sample_i) begin
            fault_count++;
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, due, sample_i);
          end
        end
      end
      mismatches_o  <= fault_count;
      samples_due_o <= sample_q.size();
    end
  end

endmodule

>>> tb/four_waveform_generator_test.sv
// Top of the four-waveform tone generator testbench: clock, reset, register
// programming, word stimulus and output backpressure, plus the verdict.
// Depends on fwg_pkg, four_waveform_generator and four_waveform_generator_checker.
module four_waveform_generator_test;

  import fwg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;  // decodes to nothing
  localparam int WordTarget  = 1950;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;  // four pipeline stages, with margin

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      restart_i   = 1'b0;
  logic                      out_stall_i = 1'b0;
  logic                      cfg_ready_o;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [SampleW-1:0] sample_o;

  int mismatches;
  int samples_due;
  int words_sent   = 0;
  int burst_left   = 0;
  bit sender_idles = 1'b0;
  int stall_style  = 1;
  bit hold_armed   = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;
  int stall_tick   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  four_waveform_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o)
  );

  four_waveform_generator_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .restart_i     (restart_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_i      (sample_o),
    .mismatches_o  (mismatches),
    .samples_due_o (samples_due)
  );

  // Receiver. One long hold-off, counted here, once the top arms it; the
  // sender keeps offering throughout so the pipeline backs up into in_stall_o.
  // Otherwise the style picked per phase: free running, light random stalls,
  // a fixed 4-in-11 pattern, or heavy random stalls.
  always @(negedge clk_i) begin
    stall_tick++;
    if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_style)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ((stall_tick % 11) < 4);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // One register write. Valid is left high on return so back-to-back writes
  // never drop and re-raise it in the same step; the caller lowers it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Every word yields a sample, so an empty scoreboard means the block is
  // idle; the extra cycles are only margin before touching the registers.
  task automatic settle();
    wait (samples_due == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Offer one word and hold it until taken. Words go out in bursts of random
  // length; between bursts the sender may sit out a random gap.
  task automatic send_word(bit flag);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = sender_idles ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    restart_i  <= flag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    words_sent++;
  endtask

  // A run of words, the first one optionally restarting the phase.
  task automatic send_words(int count, bit lead_restart);
    for (int i = 0; i < count; i++) send_word((i == 0) ? lead_restart : 1'b0);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int                  phase_no;
    int                  count;
    logic [CfgDataW-1:0] junk;
    logic [CfgDataW-1:0] step_word;
    logic [AmpW-1:0]     amp_word;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers straight out of reset: zero amplitude, so silence either way
    send_word(1'b0);
    send_word(1'b1);
    in_valid_i <= 1'b0;
    settle();

    // Full-scale sine stepping a quarter turn: hits each quadrant edge
    write_reg(RegMode, CfgDataW'(WaveSine));
    write_reg(RegAmplitude, 32'd32767);
    write_reg(RegPhaseStep, 32'h4000_0000);
    cfg_valid_i <= 1'b0;
    send_words(5, 1'b1);
    settle();

    // Square at exactly half a cycle must go negative; junk above the mode bits
    write_reg(RegMode, {30'h3FFF_FFFF, WaveSquare});
    write_reg(RegPhaseStep, 32'h8000_0000);
    cfg_valid_i <= 1'b0;
    send_words(3, 1'b1);
    settle();

    // Triangle at quarter steps; amplitude written with all upper bits set
    write_reg(RegMode, CfgDataW'(WaveTriangle));
    write_reg(RegAmplitude, 32'hFFFF_FFFF);
    write_reg(RegPhaseStep, 32'h4000_0000);
    cfg_valid_i <= 1'b0;
    send_words(4, 1'b1);
    settle();

    // Sawtooth with the largest step: the accumulator wraps on every step after the first
    write_reg(RegMode, CfgDataW'(WaveSaw));
    write_reg(RegPhaseStep, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_words(3, 1'b1);
    settle();

    // Zero step from a non-zero phase: output must hold still
    write_reg(RegPhaseStep, 32'd0);
    cfg_valid_i <= 1'b0;
    send_words(2, 1'b0);
    settle();

    // Minimum non-zero amplitude
    write_reg(RegMode, CfgDataW'(WaveSquare));
    write_reg(RegAmplitude, 32'd1);
    cfg_valid_i <= 1'b0;
    send_words(2, 1'b1);
    settle();

    // Write to the spare index must change nothing
    write_reg(RegSpare, $urandom());
    write_reg(RegPhaseStep, 32'h8000_0000);
    cfg_valid_i <= 1'b0;
    send_words(2, 1'b0);

    // Random phases: fresh settings, random idling on both sides, mostly
    // free-running phase with the odd restart
    phase_no = 0;
    while (words_sent < WordTarget) begin
      settle();
      if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
        junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        write_reg(RegMode, {junk[CfgDataW-1:ModeW], ModeW'($urandom_range(0, 3))});
      end
      if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       amp_word = '0;
          1:       amp_word = '1;
          2:       amp_word = AmpW'(1);
          default: amp_word = AmpW'($urandom());
        endcase
        junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        write_reg(RegAmplitude, {junk[CfgDataW-1:AmpW], amp_word});
      end
      if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       step_word = '0;
          1:       step_word = 32'h8000_0000;
          2:       step_word = '1;
          3:       step_word = $urandom_range(1, 1 << 20);
          4:       step_word = 32'd1 << $urandom_range(0, 31);
          default: step_word = $urandom();
        endcase
        write_reg(RegPhaseStep, step_word);
      end
      if ($urandom_range(0, 7) == 0) write_reg(RegSpare, $urandom());
      cfg_valid_i <= 1'b0;

      sender_idles = ($urandom_range(0, 2) != 0);
      stall_style  = $urandom_range(0, 3);
      count        = $urandom_range(20, 150);
      if (phase_no == 2) begin
        // long receiver hold-off with the sender pushing flat out
        sender_idles = 1'b0;
        stall_style  = 0;
        count        = 150;
        hold_armed   = 1'b1;
      end
      repeat (count) send_word($urandom_range(0, 24) == 0);
      in_valid_i <= 1'b0;
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("four_waveform_generator_test passed");
    end else begin
      $display("four_waveform_generator_test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("four_waveform_generator_test failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/fwg_pkg.sv
hdl/fwg_phase_acc.sv
hdl/fwg_wave.sv
hdl/fwg_scale.sv
hdl/four_waveform_generator.sv
hdl/fwg_checker.sv
tb/four_waveform_generator_checker.sv
tb/four_waveform_generator_test.sv
